// ===== rtl/npps_pkg.sv =====
// package for the nearest pending position server
// holds sizes, command codes, state codes and the structs passed between modules
// no dependencies
`default_nettype none

package npps_pkg;

  localparam int CAPACITY = 1024;
  localparam int POS_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = 40;
  localparam int OUT_W    = 16;
  localparam int IN_W     = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    logic             served;
    logic             dropped;
    logic [OUT_W-1:0] head_position;
    logic [OUT_W-1:0] step_distance;
    logic [SUM_W-1:0] total_distance;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/npps_if.sv =====
// channel interfaces for the nearest pending position server
// depends on npps_pkg for field widths
`default_nettype none

interface npps_in_if;
  import npps_pkg::*;
  logic            valid;
  logic            ready;
  logic            command;
  logic [IN_W-1:0] position;
  modport source (output valid, command, position, input ready);
  modport sink   (input valid, command, position, output ready);
endinterface

interface npps_out_if;
  import npps_pkg::*;
  logic             valid;
  logic             ready;
  logic             served;
  logic             dropped;
  logic [OUT_W-1:0] head_position;
  logic [OUT_W-1:0] step_distance;
  logic [SUM_W-1:0] total_distance;
  modport source (output valid, served, dropped, head_position, step_distance,
                  total_distance, input ready);
  modport sink   (input valid, served, dropped, head_position, step_distance,
                  total_distance, output ready);
endinterface

`default_nettype wire

// ===== rtl/npps_store.sv =====
// pending table: one write port and one registered read port
// depends on npps_pkg
`default_nettype none

module npps_store
  import npps_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/npps_ctrl.sv =====
// sequencer: scans the pending table, picks the free slot or the nearest entry,
// writes the table back and keeps head, direction and distance total; uses npps_pkg
`default_nettype none

module npps_ctrl
  import npps_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_command,
  input  wire logic [IN_W-1:0] in_position,
  output logic               res_valid,
  input  wire logic          res_ready,
  output res_t               res,
  output mem_req_t           mem_req,
  input  wire entry_t        rd_data
);

  state_t state_r, state_nxt;

  logic                cmd_r;
  logic [POS_BITS-1:0] pos_r;
  logic [CNT_W-1:0]    addr_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  // entries at or above the high-water mark were never written
  logic [CNT_W-1:0]    hwm_r, hwm_nxt;
  logic [POS_BITS-1:0] head_r, head_nxt;
  logic                up_r, up_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  logic                have_at_r, have_lo_r, have_hi_r, free_found_r;
  logic [IDX_W-1:0]    at_idx_r, lo_idx_r, hi_idx_r, free_idx_r;
  logic [POS_BITS-1:0] lo_v_r, hi_v_r;

  logic                accept, issue, free_hit, scan_done, finish;
  logic [POS_BITS-1:0] dlo, dhi, step;
  logic                go_up, served, dropped;
  logic [SUM_W-1:0]    room;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign issue     = (state_r == ST_SCAN) && (addr_r < hwm_r);
  assign free_hit  = (cmd_r == CMD_ADD) && rd_vld_r && !rd_data.valid;
  assign scan_done = (state_r == ST_SCAN) && ((!issue && !rd_vld_r) || free_hit);
  assign res_valid = (state_r == ST_DONE);
  assign finish    = res_valid && res_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)    state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  // decision and write-back, applied on the cycle the result leaves
  always_comb begin
    dlo      = head_r - lo_v_r;
    dhi      = hi_v_r - head_r;
    go_up    = 1'b0;
    step     = '0;
    served   = 1'b0;
    dropped  = 1'b0;
    hwm_nxt  = hwm_r;
    head_nxt = head_r;
    up_nxt   = up_r;
    sum_nxt  = sum_r;
    mem_req.rd_en   = issue;
    mem_req.rd_addr = addr_r[IDX_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = '0;
    mem_req.wr_data = '{valid: 1'b1, value: pos_r};

    if (cmd_r == CMD_ADD) begin
      if (free_found_r) begin
        mem_req.wr_en   = finish;
        mem_req.wr_addr = free_idx_r;
      end else if (hwm_r < CNT_W'(CAPACITY)) begin
        mem_req.wr_en   = finish;
        mem_req.wr_addr = hwm_r[IDX_W-1:0];
        hwm_nxt         = hwm_r + 1'b1;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      mem_req.wr_data.valid = 1'b0;
      if (have_at_r) begin
        served                = 1'b1;
        mem_req.wr_en         = finish;
        mem_req.wr_addr       = at_idx_r;
        mem_req.wr_data.value = head_r;
      end else if (have_lo_r || have_hi_r) begin
        served = 1'b1;
        if (have_lo_r && have_hi_r) begin
          if (dhi < dlo) begin
            go_up  = 1'b1;
            up_nxt = 1'b1;
          end else if (dlo < dhi) begin
            go_up  = 1'b0;
            up_nxt = 1'b0;
          end else begin
            go_up  = up_r;
          end
        end else begin
          go_up  = have_hi_r;
          up_nxt = have_hi_r;
        end
        step                  = go_up ? dhi : dlo;
        head_nxt              = go_up ? hi_v_r : lo_v_r;
        mem_req.wr_en         = finish;
        mem_req.wr_addr       = go_up ? hi_idx_r : lo_idx_r;
        mem_req.wr_data.value = head_nxt;
      end
    end

    room = SUM_MAX - sum_r;
    if (served) begin
      if (SUM_W'(step) >= room) sum_nxt = SUM_MAX;
      else                      sum_nxt = sum_r + SUM_W'(step);
    end

    res.served         = served;
    res.dropped        = dropped;
    res.head_position  = OUT_W'(head_nxt);
    res.step_distance  = OUT_W'(step);
    res.total_distance = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      hwm_r    <= '0;
      head_r   <= '0;
      up_r     <= 1'b1;
      sum_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (finish) begin
        hwm_r  <= hwm_nxt;
        head_r <= head_nxt;
        up_r   <= up_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= addr_r[IDX_W-1:0];
      addr_r   <= addr_r + 1'b1;
    end
    if (accept) begin
      cmd_r        <= in_command;
      pos_r        <= POS_BITS'(in_position);
      addr_r       <= '0;
      have_at_r    <= 1'b0;
      have_lo_r    <= 1'b0;
      have_hi_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == ST_SCAN && rd_vld_r) begin
      if (cmd_r == CMD_ADD) begin
        if (!rd_data.valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
      end else if (rd_data.valid) begin
        if (rd_data.value == head_r) begin
          if (!have_at_r) begin
            have_at_r <= 1'b1;
            at_idx_r  <= rd_idx_r;
          end
        end else if (rd_data.value < head_r) begin
          if (!have_lo_r || rd_data.value > lo_v_r) begin
            have_lo_r <= 1'b1;
            lo_idx_r  <= rd_idx_r;
            lo_v_r    <= rd_data.value;
          end
        end else begin
          if (!have_hi_r || rd_data.value < hi_v_r) begin
            have_hi_r <= 1'b1;
            hi_idx_r  <= rd_idx_r;
            hi_v_r    <= rd_data.value;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nearest_pending_position_server_unit.sv =====
// Nearest pending position server (shortest seek time first). Each input word
// either adds a position to a table of 1024 pending entries or serves the pending
// entry nearest the head, and yields exactly one result word. Timing is set by the
// single read port of the pending table, which is scanned one entry per cycle up
// to the high-water mark of slots ever filled (at most 1024). A serve scans up to
// that mark; an add stops at the first free slot, or scans up to the mark when no
// hole exists. The next word can be taken once the result is registered. No
// clearing pass is needed after reset. A finished result sits in an output
// register so the next word can be taken while it waits.
// depends on npps_pkg, npps_if, npps_store, npps_ctrl
`default_nettype none

module nearest_pending_position_server_unit
  import npps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  npps_in_if.sink   in_ch,
  npps_out_if.source out_ch
);

  mem_req_t mem_req;
  entry_t   rd_data;
  res_t     res;
  logic     res_valid, res_ready;
  logic     out_valid_r;
  res_t     out_data_r;

  npps_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  npps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_command  (in_ch.command),
    .in_position (in_ch.position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  // output register frees up as the word is taken
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.served         = out_data_r.served;
  assign out_ch.dropped        = out_data_r.dropped;
  assign out_ch.head_position  = out_data_r.head_position;
  assign out_ch.step_distance  = out_data_r.step_distance;
  assign out_ch.total_distance = out_data_r.total_distance;

endmodule

`default_nettype wire
